>>> sv/i8080alu_pkg.sv
// ----------------------------------------------------------------------------
// i8080alu_pkg
// Shared types, operation codes and flag helpers for the 8080-style ALU.
// ----------------------------------------------------------------------------
package i8080alu_pkg;

    // Operation codes carried on the func port.
    localparam logic [4:0] FUNC_ADD = 5'd0;
    localparam logic [4:0] FUNC_ADC = 5'd1;
    localparam logic [4:0] FUNC_SUB = 5'd2;
    localparam logic [4:0] FUNC_SBB = 5'd3;
    localparam logic [4:0] FUNC_ANA = 5'd4;
    localparam logic [4:0] FUNC_XRA = 5'd5;
    localparam logic [4:0] FUNC_ORA = 5'd6;
    localparam logic [4:0] FUNC_CMP = 5'd7;
    localparam logic [4:0] FUNC_INR = 5'd8;
    localparam logic [4:0] FUNC_DCR = 5'd9;
    localparam logic [4:0] FUNC_RLC = 5'd10;
    localparam logic [4:0] FUNC_RRC = 5'd11;
    localparam logic [4:0] FUNC_RAL = 5'd12;
    localparam logic [4:0] FUNC_RAR = 5'd13;
    localparam logic [4:0] FUNC_DAA = 5'd14;
    localparam logic [4:0] FUNC_CMA = 5'd15;
    localparam logic [4:0] FUNC_STC = 5'd16;
    localparam logic [4:0] FUNC_CMC = 5'd17;

    // Bit positions inside the packed flag word.
    localparam int FL_CY = 0;
    localparam int FL_P  = 1;
    localparam int FL_AC = 2;
    localparam int FL_Z  = 3;
    localparam int FL_S  = 4;

    typedef logic [4:0] flags_t;

    // One ALU result word.
    typedef struct packed {
        logic [7:0] result;
        flags_t     flags;
        logic       written;
    } alu_out_t;

    // Sign, zero and parity flags of a result byte; AC and CY are left clear.
    function automatic flags_t szp_of(input logic [7:0] r);
        flags_t f;
        f        = '0;
        f[FL_S]  = r[7];
        f[FL_Z]  = (r == 8'h00);
        f[FL_P]  = ~(^r);
        return f;
    endfunction

endpackage

>>> sv/i8080alu_core.sv
// ----------------------------------------------------------------------------
// i8080alu_core
// Combinational ALU datapath: one shared 8-bit adder plus logic, rotate
// and flag selection.
// ----------------------------------------------------------------------------
module i8080alu_core
    import i8080alu_pkg::*;
(
    input  logic [4:0] func,
    input  logic [7:0] acc_in,
    input  logic [7:0] operand,
    input  flags_t     flags_in,
    output alu_out_t   alu_out
);

    logic       cy;
    logic [7:0] add_b;
    logic       add_cin;
    logic [8:0] sum;
    logic [4:0] nib_sum;
    logic       ac;
    logic [7:0] daa_corr;
    logic       daa_cy;
    logic [7:0] res;
    flags_t     fl;
    logic       wr;

    assign cy = flags_in[FL_CY];

    // Decimal adjust correction term and its carry.
    always_comb
    begin
        daa_corr = 8'h00;
        daa_cy   = cy;
        if ((acc_in[3:0] > 4'd9) || flags_in[FL_AC])
        begin
            daa_corr[3:0] = 4'h6;
        end
        if (cy || (acc_in > 8'h99))
        begin
            daa_corr[7:4] = 4'h6;
            daa_cy        = 1'b1;
        end
    end

    // Addend and carry in for the shared adder.
    always_comb
    begin
        add_b   = operand;
        add_cin = 1'b0;
        case (func)
            FUNC_ADC:
            begin
                add_cin = cy;
            end
            FUNC_SUB, FUNC_CMP:
            begin
                add_b   = ~operand;
                add_cin = 1'b1;
            end
            FUNC_SBB:
            begin
                add_b   = ~operand;
                add_cin = ~cy;
            end
            FUNC_INR:
            begin
                add_b = 8'h01;
            end
            FUNC_DCR:
            begin
                add_b = 8'hFF;
            end
            FUNC_DAA:
            begin
                add_b = daa_corr;
            end
            default:
            begin
                add_b   = operand;
                add_cin = 1'b0;
            end
        endcase
    end

    // Shared adder with the carry out of bit 3.
    assign sum     = {1'b0, acc_in} + {1'b0, add_b} + {8'h00, add_cin};
    assign nib_sum = {1'b0, acc_in[3:0]} + {1'b0, add_b[3:0]} + {4'h0, add_cin};
    assign ac      = nib_sum[4];

    // Result and flag selection.
    always_comb
    begin
        res = acc_in;
        fl  = flags_in;
        wr  = 1'b1;
        case (func)
            FUNC_ADD, FUNC_ADC:
            begin
                res        = sum[7:0];
                fl         = szp_of(sum[7:0]);
                fl[FL_AC]  = ac;
                fl[FL_CY]  = sum[8];
            end
            FUNC_SUB, FUNC_SBB, FUNC_CMP:
            begin
                fl         = szp_of(sum[7:0]);
                fl[FL_AC]  = ac;
                fl[FL_CY]  = ~sum[8];
                if (func == FUNC_CMP)
                begin
                    wr = 1'b0;
                end
                else
                begin
                    res = sum[7:0];
                end
            end
            FUNC_ANA:
            begin
                res        = acc_in & operand;
                fl         = szp_of(acc_in & operand);
                fl[FL_AC]  = acc_in[3] | operand[3];
            end
            FUNC_XRA:
            begin
                res = acc_in ^ operand;
                fl  = szp_of(acc_in ^ operand);
            end
            FUNC_ORA:
            begin
                res = acc_in | operand;
                fl  = szp_of(acc_in | operand);
            end
            FUNC_INR, FUNC_DCR:
            begin
                res        = sum[7:0];
                fl         = szp_of(sum[7:0]);
                fl[FL_AC]  = ac;
                fl[FL_CY]  = cy;
            end
            FUNC_RLC:
            begin
                res       = {acc_in[6:0], acc_in[7]};
                fl[FL_CY] = acc_in[7];
            end
            FUNC_RRC:
            begin
                res       = {acc_in[0], acc_in[7:1]};
                fl[FL_CY] = acc_in[0];
            end
            FUNC_RAL:
            begin
                res       = {acc_in[6:0], cy};
                fl[FL_CY] = acc_in[7];
            end
            FUNC_RAR:
            begin
                res       = {cy, acc_in[7:1]};
                fl[FL_CY] = acc_in[0];
            end
            FUNC_DAA:
            begin
                res        = sum[7:0];
                fl         = szp_of(sum[7:0]);
                fl[FL_AC]  = ac;
                fl[FL_CY]  = daa_cy;
            end
            FUNC_CMA:
            begin
                res = ~acc_in;
            end
            FUNC_STC:
            begin
                fl[FL_CY] = 1'b1;
                wr        = 1'b0;
            end
            FUNC_CMC:
            begin
                fl[FL_CY] = ~cy;
                wr        = 1'b0;
            end
            default:
            begin
                // Undefined codes leave everything untouched.
                wr = 1'b0;
            end
        endcase
    end

    assign alu_out.result  = res;
    assign alu_out.flags   = fl;
    assign alu_out.written = wr;

endmodule

>>> sv/i8080_alu_with_flags.sv
// ----------------------------------------------------------------------------
// i8080_alu_with_flags
// Accumulator ALU of an 8080-style processor with registered inputs and
// registered results.
// ----------------------------------------------------------------------------
//  Channel   Handshake         Word
//  -------   ---------------   ------------------------------------------
//  command   start / busy      func, acc_in, operand, flags_in
//  result    done (strobe)     result, flags_out, result_written
//
//  A command accepted into the input registers passes through the core
//  to the result register, which drives the result ports, with done high
//  for exactly one cycle. busy is always low: one command may be accepted
//  at every edge, limited only by the combinational adder and flag path
//  between the input and result registers.
//  Reset clears both valid bits. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module i8080_alu_with_flags
    import i8080alu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [4:0] func,
    input  logic [7:0] acc_in,
    input  logic [7:0] operand,
    input  logic [4:0] flags_in,
    output logic       done,
    output logic [7:0] result,
    output logic [4:0] flags_out,
    output logic       result_written
);

    logic       in_valid_reg;
    logic [4:0] func_reg;
    logic [7:0] acc_reg;
    logic [7:0] operand_reg;
    flags_t     flags_reg;

    alu_out_t   out_next;
    logic       out_valid_reg;
    alu_out_t   out_reg;

    assign busy = 1'b0;

    // Input register: valid bit under reset, payload captured on accept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            func_reg    <= func;
            acc_reg     <= acc_in;
            operand_reg <= operand;
            flags_reg   <= flags_in;
        end
    end

    // Datapath between the two register stages.
    i8080alu_core u_core
    (
        .func     (func_reg),
        .acc_in   (acc_reg),
        .operand  (operand_reg),
        .flags_in (flags_reg),
        .alu_out  (out_next)
    );

    // Result register and its strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign done           = out_valid_reg;
    assign result         = out_reg.result;
    assign flags_out      = out_reg.flags;
    assign result_written = out_reg.written;

endmodule

>>> tb/tb_i8080_alu_with_flags.sv
// ----------------------------------------------------------------------------
// tb_i8080_alu_with_flags
// Self-checking bench for the 8080-style accumulator ALU. A local model of
// the ALU predicts the result word of every accepted command word. A checker
// compares each done strobe against the oldest prediction, field by field.
// Directed corners come first. Random streams with and without gaps follow,
// along with batches that let the pipeline drain between them.
// ----------------------------------------------------------------------------
module tb_i8080_alu_with_flags
    import i8080alu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 60000;
    localparam int GAP_PERCENT = 7;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic [4:0] func = '0;
    logic [7:0] acc_in = '0;
    logic [7:0] operand = '0;
    logic [4:0] flags_in = '0;
    logic       busy;
    logic       done;
    logic [7:0] result;
    logic [4:0] flags_out;
    logic       result_written;

    alu_out_t pending_outcomes[$];
    int       words_sent = 0;
    int       words_checked = 0;
    int       error_count = 0;
    int       cycle_count = 0;

    i8080_alu_with_flags uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .acc_in         (acc_in),
        .operand        (operand),
        .flags_in       (flags_in),
        .done           (done),
        .result         (result),
        .flags_out      (flags_out),
        .result_written (result_written)
    );

    // Free-running 2 ns clock.
    initial
    begin
        forever #1 clk = ~clk;
    end

    // Sign, zero and even parity of a byte, other flag bits clear.
    function automatic flags_t szp_flags(input logic [7:0] r);
        flags_t f;
        f        = '0;
        f[FL_S]  = r[7];
        f[FL_Z]  = (r == 8'h00);
        f[FL_P]  = ~(^r);
        return f;
    endfunction

    // Carry out of bit 3 when two bytes and a carry are added.
    function automatic logic nibble_carry(input logic [7:0] a, input logic [7:0] b,
                                          input logic cin);
        logic [4:0] low_sum;
        low_sum = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, cin};
        return low_sum[4];
    endfunction

    // Expected result word for one command word.
    function automatic alu_out_t alu_outcome(input logic [4:0] op, input logic [7:0] a,
                                             input logic [7:0] b, input flags_t fin);
        alu_out_t   o;
        logic [8:0] sum;
        logic [7:0] addend;
        logic [7:0] corr;
        logic       cin;
        logic       cy;
        logic       ncy;
        cy        = fin[FL_CY];
        o.result  = a;
        o.flags   = fin;
        o.written = 1'b1;
        case (op)
            FUNC_ADD, FUNC_ADC:
            begin
                cin = (op == FUNC_ADC) ? cy : 1'b0;
                sum = {1'b0, a} + {1'b0, b} + {8'b0, cin};
                o.result = sum[7:0];
                o.flags = szp_flags(sum[7:0]);
                o.flags[FL_AC] = nibble_carry(a, b, cin);
                o.flags[FL_CY] = sum[8];
            end
            FUNC_SUB, FUNC_SBB, FUNC_CMP:
            begin
                // Subtraction adds the complement; carry holds the borrow.
                addend = ~b;
                cin = (op == FUNC_SBB) ? ~cy : 1'b1;
                sum = {1'b0, a} + {1'b0, addend} + {8'b0, cin};
                o.flags = szp_flags(sum[7:0]);
                o.flags[FL_AC] = nibble_carry(a, addend, cin);
                o.flags[FL_CY] = ~sum[8];
                if (op == FUNC_CMP)
                    o.written = 1'b0;
                else
                    o.result = sum[7:0];
            end
            FUNC_ANA:
            begin
                o.result = a & b;
                o.flags = szp_flags(o.result);
                o.flags[FL_AC] = a[3] | b[3];
            end
            FUNC_XRA:
            begin
                o.result = a ^ b;
                o.flags = szp_flags(o.result);
            end
            FUNC_ORA:
            begin
                o.result = a | b;
                o.flags = szp_flags(o.result);
            end
            FUNC_INR, FUNC_DCR:
            begin
                // Step by one; the carry flag is kept.
                addend = (op == FUNC_INR) ? 8'h01 : 8'hFF;
                sum = {1'b0, a} + {1'b0, addend};
                o.result = sum[7:0];
                o.flags = szp_flags(sum[7:0]);
                o.flags[FL_AC] = nibble_carry(a, addend, 1'b0);
                o.flags[FL_CY] = cy;
            end
            FUNC_RLC:
            begin
                o.result = {a[6:0], a[7]};
                o.flags[FL_CY] = a[7];
            end
            FUNC_RRC:
            begin
                o.result = {a[0], a[7:1]};
                o.flags[FL_CY] = a[0];
            end
            FUNC_RAL:
            begin
                o.result = {a[6:0], cy};
                o.flags[FL_CY] = a[7];
            end
            FUNC_RAR:
            begin
                o.result = {cy, a[7:1]};
                o.flags[FL_CY] = a[0];
            end
            FUNC_DAA:
            begin
                corr = 8'h00;
                ncy = cy;
                if (a[3:0] > 4'd9 || fin[FL_AC])
                    corr[3:0] = 4'h6;
                if (cy || a > 8'h99)
                begin
                    corr[7:4] = 4'h6;
                    ncy = 1'b1;
                end
                sum = {1'b0, a} + {1'b0, corr};
                o.result = sum[7:0];
                o.flags = szp_flags(sum[7:0]);
                o.flags[FL_AC] = nibble_carry(a, corr, 1'b0);
                o.flags[FL_CY] = ncy;
            end
            FUNC_CMA:
            begin
                o.result = ~a;
            end
            FUNC_STC:
            begin
                o.flags[FL_CY] = 1'b1;
                o.written = 1'b0;
            end
            FUNC_CMC:
            begin
                o.flags[FL_CY] = ~cy;
                o.written = 1'b0;
            end
            default:
            begin
                o.written = 1'b0;
            end
        endcase
        return o;
    endfunction

    // One line per mismatch, and a count.
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("MISMATCH %s: got %h, expected %h (cycle %0d)", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // Drive one command word and hold it until it is accepted.
    task automatic send_word(input logic [4:0] op, input logic [7:0] a,
                             input logic [7:0] b, input flags_t f);
        start    <= 1'b1;
        func     <= op;
        acc_in   <= a;
        operand  <= b;
        flags_in <= f;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_outcomes.push_back(alu_outcome(op, a, b, f));
        words_sent++;
    endtask

    // Sometimes drop start and idle so gaps land on every pipeline phase.
    task automatic maybe_gap();
        if ($urandom_range(0, 99) < GAP_PERCENT)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // One random command word, biased toward byte extremes and valid opcodes.
    task automatic send_random_word(input bit gaps);
        logic [4:0] op;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] corner_values[6];
        corner_values = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h99, 8'h9A};
        if ($urandom_range(0, 9) == 0)
            op = 5'($urandom_range(FUNC_CMC + 1, 31));
        else
            op = 5'($urandom_range(FUNC_ADD, FUNC_CMC));
        a = 8'($urandom);
        b = 8'($urandom);
        if ($urandom_range(0, 4) == 0)
            a = corner_values[$urandom_range(0, 5)];
        if ($urandom_range(0, 4) == 0)
            b = corner_values[$urandom_range(0, 5)];
        send_word(op, a, b, 5'($urandom_range(0, 31)));
        if (gaps)
            maybe_gap();
    endtask

    // Every operation at its edge cases: carries, borrows, wraps, DAA paths.
    task automatic test_directed_corners();
        send_word(FUNC_ADD, 8'hFF, 8'h01, 5'h00);
        send_word(FUNC_ADC, 8'h7F, 8'h00, 5'h01);
        send_word(FUNC_SUB, 8'h00, 8'h01, 5'h1F);
        send_word(FUNC_SBB, 8'h00, 8'hFF, 5'h01);
        send_word(FUNC_CMP, 8'h42, 8'h42, 5'h00);
        send_word(FUNC_CMP, 8'h10, 8'h20, 5'h00);
        maybe_gap();
        send_word(FUNC_ANA, 8'hF7, 8'h08, 5'h1F);
        send_word(FUNC_XRA, 8'hFF, 8'hFF, 5'h00);
        send_word(FUNC_ORA, 8'h00, 8'h00, 5'h1F);
        send_word(FUNC_INR, 8'hFF, 8'h00, 5'h01);
        send_word(FUNC_DCR, 8'h00, 8'hFF, 5'h00);
        maybe_gap();
        send_word(FUNC_RLC, 8'h80, 8'h00, 5'h00);
        send_word(FUNC_RRC, 8'h01, 8'h00, 5'h00);
        send_word(FUNC_RAL, 8'h80, 8'h00, 5'h1E);
        send_word(FUNC_RAR, 8'h01, 8'h00, 5'h01);
        // Decimal adjust: both nibbles high, carry in, aux carry in, nothing to do.
        send_word(FUNC_DAA, 8'h9A, 8'h00, 5'h00);
        send_word(FUNC_DAA, 8'h99, 8'h00, 5'h01);
        send_word(FUNC_DAA, 8'h05, 8'h00, 5'h04);
        send_word(FUNC_DAA, 8'h00, 8'h00, 5'h00);
        maybe_gap();
        send_word(FUNC_CMA, 8'h55, 8'hAA, 5'h0A);
        send_word(FUNC_STC, 8'h3C, 8'h00, 5'h00);
        send_word(FUNC_CMC, 8'hC3, 8'h00, 5'h1F);
        // Unused codes must leave everything alone.
        send_word(FUNC_CMC + 5'd1, 8'hA5, 8'h5A, 5'h15);
        send_word(5'd31, 8'hFF, 8'hFF, 5'h1F);
        maybe_gap();
    endtask

    // Random words with occasional idle cycles on the command side.
    task automatic test_random_gapped(input int count);
        repeat (count) send_random_word(1'b1);
    endtask

    // Random words at full rate, one per clock.
    task automatic test_random_back_to_back(input int count);
        repeat (count) send_random_word(1'b0);
    endtask

    // Batches separated by a full drain of the pipeline.
    task automatic test_drain_between_batches(input int batches, input int per_batch);
        repeat (batches)
        begin
            repeat (per_batch) send_random_word(1'b1);
            start <= 1'b0;
            while (pending_outcomes.size() != 0)
                @(posedge clk);
        end
    endtask

    // Result checker: every done strobe against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        alu_out_t want;
        if (done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                report_mismatch("result with nothing pending", result, 8'h00);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                words_checked++;
                if (result !== want.result)
                    report_mismatch("result", result, want.result);
                if (flags_out !== want.flags)
                    report_mismatch("flags_out", {3'b0, flags_out}, {3'b0, want.flags});
                if (result_written !== want.written)
                    report_mismatch("result_written", {7'b0, result_written},
                                    {7'b0, want.written});
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results pending", cycle_count,
                     pending_outcomes.size());
            $display("tb_i8080_alu_with_flags failed");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_random_gapped(200);
        test_random_back_to_back(200);
        test_drain_between_batches(4, 50);

        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d words and checked %0d results over all eighteen operations,",
                 words_sent, words_checked);
        $display("unused codes, gapped, full-rate and drained streams.");
        if (error_count == 0)
            $display("tb_i8080_alu_with_flags passed");
        else
            $display("tb_i8080_alu_with_flags failed");
        $finish;
    end

endmodule

>>> files.f
sv/i8080alu_pkg.sv
sv/i8080alu_core.sv
sv/i8080_alu_with_flags.sv
tb/tb_i8080_alu_with_flags.sv
